/* hw/rtl/lab_pkg.sv */
package lab_pkg;

  localparam int NORM_STEPS = 5;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  // Abs, max/prescale, square, sum and sign stages plus the three step chains.
  localparam int UNIT_LAT   = 5 + NORM_STEPS + SQRT_STEPS + DIV_STEPS;

  localparam int DIR_W = 33;
  localparam int VEC_W = 18;
  localparam int Z_W   = 19;

  localparam logic [VEC_W-1:0] VERT_LIMIT = 18'd65470;

  typedef struct packed {
    logic [63:0] n;
    logic [32:0] rem;
    logic [31:0] root;
  } isq_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [16:0] q;
  } div_t;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  // One digit of a restoring square root: two radicand bits in, one root bit out.
  function automatic isq_t isq_step(input isq_t s);
    isq_t        o;
    logic [34:0] cur;
    logic [34:0] trial;
    cur   = {s.rem, s.n[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o.n   = {s.n[61:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = 33'(cur - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = cur[32:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of a restoring division by l.
  function automatic div_t div_step(input div_t s, input logic [31:0] l);
    div_t        o;
    logic        take;
    logic [32:0] r;
    take  = (s.rem >= {1'b0, l});
    r     = take ? (s.rem - {1'b0, l}) : s.rem;
    o.rem = {r[31:0], 1'b0};
    o.q   = {s.q[15:0], take};
    return o;
  endfunction

endpackage

/* hw/rtl/look_at_basis_matrix.sv */
// A word accepted at a clock edge moves through the registered pipeline to the
// result ports; done marks it for one cycle.
// Throughput: one word per cycle outside reset. The depth is set by two normalizations in
// series, each a 32-step square root and a 17-step divider, one step a stage.
// Reset (rst, synchronous) empties the valid pipeline; busy is high only in reset.
module look_at_basis_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic               done,
  output logic signed [31:0] right_x,
  output logic signed [31:0] right_y,
  output logic signed [31:0] right_z,
  output logic signed [31:0] facing_x,
  output logic signed [31:0] facing_y,
  output logic signed [31:0] facing_z,
  output logic signed [31:0] third_x,
  output logic signed [31:0] third_y,
  output logic signed [31:0] third_z,
  output logic               degenerate
);

  localparam int UL       = lab_pkg::UNIT_LAT;
  localparam int SS       = lab_pkg::SQRT_STEPS;
  localparam int VW       = lab_pkg::VEC_W;
  localparam int DW       = lab_pkg::DIR_W;
  localparam int ZW       = lab_pkg::Z_W;
  localparam int Y_AT     = 1 + UL;
  localparam int CR_AT    = Y_AT + 1;
  localparam int X_AT     = CR_AT + UL;
  localparam int MUL_AT   = X_AT + 1;
  localparam int Z_AT     = MUL_AT + 1;
  localparam int SC_AT    = Z_AT + 1;
  localparam int OUT_AT   = SC_AT + 1;
  localparam int SCALE_AT = 2 + SS;
  localparam int YD_LEN   = Z_AT - Y_AT;
  localparam int YI_X     = X_AT - Y_AT - 1;
  localparam int SD_LEN   = Z_AT - SCALE_AT;

  logic              accept;
  logic [OUT_AT:0]   vld;

  logic signed [31:0] pos_r [3];
  logic signed [31:0] ax_r  [3];
  logic signed [31:0] tg_r  [3];
  logic [31:0]        ax_m  [3];

  logic signed [DW-1:0] dir1 [3];
  logic [63:0]          axq  [3];
  lab_pkg::isq_t        sc   [SS+1];
  logic [31:0]          sdl  [SD_LEN];

  logic signed [VW-1:0] ya [3];
  logic                 za;
  logic signed [DW-1:0] cr [3];
  logic [VW-1:0]        ya1_mag;
  logic signed [VW-1:0] xb [3];
  logic                 zb;

  logic signed [VW-1:0] ydl  [YD_LEN][3];
  logic                 ydeg [YD_LEN];

  logic signed [2*VW-1:0] pr [6];
  logic signed [VW-1:0]   xm [3];
  logic                   deg_m;
  logic signed [2*VW:0]   zd [3];
  logic signed [ZW-1:0]   zz [3];
  logic signed [VW-1:0]   xz [3];
  logic                   deg_z;
  logic signed [51:0]     prod [9];
  logic                   deg_s;
  logic signed [31:0]     rout [9];

  function automatic logic signed [31:0] sat_q(input logic signed [51:0] p);
    logic signed [35:0] v;
    v = 36'(p >>> 16);
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      return v[31:0];
    end else if (v[35]) begin
      return 32'sh80000000;
    end else begin
      return 32'sh7fffffff;
    end
  endfunction

  assign busy   = rst;
  assign accept = start && !rst;
  assign done   = vld[OUT_AT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_AT-1:0], accept};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax_m[i] = ax_r[i][31] ? 32'(-ax_r[i]) : 32'(ax_r[i]);
    end
    ya1_mag = ya[1][VW-1] ? VW'(-ya[1]) : VW'(ya[1]);
  end

  lab_unit u_face (
    .clk  (clk),
    .vin  (dir1),
    .vout (ya),
    .zero (za)
  );

  lab_unit u_right (
    .clk  (clk),
    .vin  (cr),
    .vout (xb),
    .zero (zb)
  );

  always_ff @(posedge clk) begin
    pos_r[0] <= pos_x;    pos_r[1] <= pos_y;    pos_r[2] <= pos_z;
    ax_r[0]  <= axis_x;   ax_r[1]  <= axis_y;   ax_r[2]  <= axis_z;
    tg_r[0]  <= target_x; tg_r[1]  <= target_y; tg_r[2]  <= target_z;

    for (int i = 0; i < 3; i++) begin
      dir1[i] <= DW'(tg_r[i]) - DW'(pos_r[i]);
      axq[i]  <= 64'(ax_m[i]) * 64'(ax_m[i]);
    end

    // Scale is the length of the registered axis vector.
    sc[0] <= {axq[0] + axq[1] + axq[2], 33'd0, 32'd0};
    for (int k = 0; k < SS; k++) begin
      sc[k+1] <= lab_pkg::isq_step(sc[k]);
    end
    sdl[0] <= sc[SS].root;
    for (int k = 1; k < SD_LEN; k++) begin
      sdl[k] <= sdl[k-1];
    end

    // Near vertical facing switches the up vector from world Y to world Z.
    if (ya1_mag > lab_pkg::VERT_LIMIT) begin
      cr[0] <= DW'(-ya[1]);
      cr[1] <= DW'(ya[0]);
      cr[2] <= '0;
    end else begin
      cr[0] <= DW'(ya[2]);
      cr[1] <= '0;
      cr[2] <= DW'(-ya[0]);
    end

    ydl[0]  <= ya;
    ydeg[0] <= za;
    for (int k = 1; k < YD_LEN; k++) begin
      ydl[k]  <= ydl[k-1];
      ydeg[k] <= ydeg[k-1];
    end

    pr[0] <= xb[1] * ydl[YI_X][2];
    pr[1] <= xb[2] * ydl[YI_X][1];
    pr[2] <= xb[2] * ydl[YI_X][0];
    pr[3] <= xb[0] * ydl[YI_X][2];
    pr[4] <= xb[0] * ydl[YI_X][1];
    pr[5] <= xb[1] * ydl[YI_X][0];
    xm    <= xb;
    deg_m <= ydeg[YI_X] || zb;

    for (int i = 0; i < 3; i++) begin
      zz[i] <= ZW'(zd[i] >>> 16);
    end
    xz    <= xm;
    deg_z <= deg_m;

    for (int i = 0; i < 3; i++) begin
      prod[i]     <= xz[i] * signed'({1'b0, sdl[SD_LEN-1]});
      prod[3 + i] <= ydl[YD_LEN-1][i] * signed'({1'b0, sdl[SD_LEN-1]});
      prod[6 + i] <= zz[i] * signed'({1'b0, sdl[SD_LEN-1]});
    end
    deg_s <= deg_z;

    for (int i = 0; i < 9; i++) begin
      rout[i] <= sat_q(prod[i]);
    end
    degenerate <= deg_s;
  end

  always_comb begin
    zd[0] = (2*VW+1)'(pr[0]) - (2*VW+1)'(pr[1]);
    zd[1] = (2*VW+1)'(pr[2]) - (2*VW+1)'(pr[3]);
    zd[2] = (2*VW+1)'(pr[4]) - (2*VW+1)'(pr[5]);
  end

  assign right_x  = rout[0];
  assign right_y  = rout[1];
  assign right_z  = rout[2];
  assign facing_x = rout[3];
  assign facing_y = rout[4];
  assign facing_z = rout[5];
  assign third_x  = rout[6];
  assign third_y  = rout[7];
  assign third_z  = rout[8];

`ifndef SYNTHESIS
  a_done_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, OUT_AT + 1))
    else $error("result word without a matching input word");

  a_degenerate_zero : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (right_x == 0 && right_y == 0 && right_z == 0 &&
      facing_x == 0 && facing_y == 0 && facing_z == 0 &&
      third_x == 0 && third_y == 0 && third_z == 0))
    else $error("degenerate result with a nonzero basis entry");
`endif

endmodule

/* hw/rtl/lab_unit.sv */
module lab_unit (
  input  logic                                clk,
  input  logic signed [lab_pkg::DIR_W-1:0]    vin [3],
  output logic signed [lab_pkg::VEC_W-1:0]    vout [3],
  output logic                                zero
);

  localparam int NS = lab_pkg::NORM_STEPS;
  localparam int SS = lab_pkg::SQRT_STEPS;
  localparam int DS = lab_pkg::DIV_STEPS;

  logic [lab_pkg::DIR_W-1:0] mag_a [3];
  logic [2:0]                neg_a;
  logic [lab_pkg::DIR_W-1:0] mx_a;

  logic [31:0]   nm   [NS+1][3];
  logic [31:0]   nmx  [NS+1];
  logic [2:0]    nneg [NS+1];
  logic          nzero[NS+1];

  logic [63:0]    sq [3];
  lab_pkg::side_t sd_q;

  lab_pkg::isq_t  st [SS+1];
  lab_pkg::side_t sd [SS+1];

  lab_pkg::div_t  dv0 [3];
  lab_pkg::div_t  dv  [DS][3];
  logic [31:0]    dl  [DS];
  lab_pkg::side_t ds  [DS];

  always_comb begin
    mx_a = mag_a[0];
    if (mag_a[1] > mx_a) mx_a = mag_a[1];
    if (mag_a[2] > mx_a) mx_a = mag_a[2];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv0[i].rem = {1'b0, sd[SS].mag[i]};
      dv0[i].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_a[i] <= vin[i][lab_pkg::DIR_W-1];
      mag_a[i] <= vin[i][lab_pkg::DIR_W-1] ? lab_pkg::DIR_W'(-vin[i]) : lab_pkg::DIR_W'(vin[i]);
    end

    // A magnitude of 2^31 or more is halved; smaller ones are scaled up later.
    nzero[0] <= (mx_a == '0);
    nneg[0]  <= neg_a;
    nmx[0]   <= (mx_a[32:31] != 2'b00) ? mx_a[32:1] : mx_a[31:0];
    for (int i = 0; i < 3; i++) begin
      nm[0][i] <= (mx_a[32:31] != 2'b00) ? mag_a[i][32:1] : mag_a[i][31:0];
    end

    // Binary leading-zero search: shift by 16, 8, 4, 2, 1 until bit 30 or 31 is set.
    for (int k = 0; k < NS; k++) begin
      nzero[k+1] <= nzero[k];
      nneg[k+1]  <= nneg[k];
      if ((nmx[k] >> (31 - (16 >> k))) == 32'd0) begin
        nmx[k+1] <= nmx[k] << (16 >> k);
        for (int i = 0; i < 3; i++) begin
          nm[k+1][i] <= nm[k][i] << (16 >> k);
        end
      end else begin
        nmx[k+1] <= nmx[k];
        for (int i = 0; i < 3; i++) begin
          nm[k+1][i] <= nm[k][i];
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      sq[i]          <= 64'(nm[NS][i]) * 64'(nm[NS][i]);
      sd_q.mag[i]    <= nm[NS][i];
    end
    sd_q.neg  <= nneg[NS];
    sd_q.zero <= nzero[NS];

    st[0] <= {sq[0] + sq[1] + sq[2], 33'd0, 32'd0};
    sd[0] <= sd_q;
    for (int k = 0; k < SS; k++) begin
      st[k+1] <= lab_pkg::isq_step(st[k]);
      sd[k+1] <= sd[k];
    end

    for (int i = 0; i < 3; i++) begin
      dv[0][i] <= lab_pkg::div_step(dv0[i], st[SS].root);
    end
    dl[0] <= st[SS].root;
    ds[0] <= sd[SS];
    for (int k = 1; k < DS; k++) begin
      for (int i = 0; i < 3; i++) begin
        dv[k][i] <= lab_pkg::div_step(dv[k-1][i], dl[k-1]);
      end
      dl[k] <= dl[k-1];
      ds[k] <= ds[k-1];
    end

    for (int i = 0; i < 3; i++) begin
      if (ds[DS-1].zero) begin
        vout[i] <= '0;
      end else if (ds[DS-1].neg[i]) begin
        vout[i] <= -signed'({1'b0, dv[DS-1][i].q});
      end else begin
        vout[i] <= signed'({1'b0, dv[DS-1][i].q});
      end
    end
    zero <= ds[DS-1].zero;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY   = 125;
  localparam int MAX_CYCLE = 400000;
  localparam logic signed [63:0] VERT_Q16 = 64'sd65470;

  typedef struct {
    logic signed [31:0] b [9];
    logic               deg;
  } basis_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic done;
  logic signed [31:0] right_x, right_y, right_z;
  logic signed [31:0] facing_x, facing_y, facing_z;
  logic signed [31:0] third_x, third_y, third_z;
  logic degenerate;

  basis_t expected_basis[$];
  int     errors = 0;
  int     cycle = 0;
  int     words_sent = 0;
  int     words_checked = 0;
  int     degenerate_seen = 0;
  int     idle_pct = 0;

  look_at_basis_matrix dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .done(done),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .facing_x(facing_x), .facing_y(facing_y), .facing_z(facing_z),
    .third_x(third_x), .third_y(third_y), .third_z(third_z),
    .degenerate(degenerate)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bits;
    res  = 0;
    bits = 64'd1 << 62;
    while (bits > n) bits = bits >> 2;
    while (bits != 0) begin
      if (n >= res + bits) begin
        n   = n - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] q16_floor(input logic signed [63:0] v);
    return v >>> 16;
  endfunction

  // Scales a vector to Q16.16 unit length; returns 1 when it is all zero.
  function automatic logic unit_vector(input logic signed [63:0] v [3],
                                       output logic signed [63:0] u [3]);
    logic [63:0] mag [3];
    logic        neg [3];
    logic [63:0] peak, sum, len;
    peak = 0;
    sum  = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    if (peak >= 64'd1 << 31) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end else begin
      while (peak < 64'd1 << 30) begin
        peak = peak << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      u[i] = $signed((mag[i] * 64'd65536) / len);
      if (neg[i]) u[i] = -u[i];
    end
    return 1'b0;
  endfunction

  function automatic logic signed [31:0] scale_sat(input logic signed [63:0] c,
                                                   input logic [63:0] s);
    logic signed [63:0] v;
    v = q16_floor(c * $signed(s));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic basis_t billboard_basis(input logic signed [31:0] p [3],
                                             input logic signed [31:0] a [3],
                                             input logic signed [31:0] t [3]);
    basis_t r;
    logic signed [63:0] dir [3], yv [3], cr [3], xv [3], zv [3];
    logic [63:0] sq, m, s;
    logic d;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m      = a[i] < 0 ? -64'(a[i]) : 64'(a[i]);
      sq     = sq + m * m;
      dir[i] = 64'(t[i]) - 64'(p[i]);
    end
    s = int_sqrt(sq);
    d = unit_vector(dir, yv);
    // Near vertical, the up vector switches from world Y to world Z.
    if ((yv[1] < 0 ? -yv[1] : yv[1]) > VERT_Q16) begin
      cr[0] = -yv[1]; cr[1] = yv[0]; cr[2] = 0;
    end else begin
      cr[0] = yv[2];  cr[1] = 0;     cr[2] = -yv[0];
    end
    if (unit_vector(cr, xv)) d = 1'b1;
    zv[0] = q16_floor(xv[1] * yv[2] - xv[2] * yv[1]);
    zv[1] = q16_floor(xv[2] * yv[0] - xv[0] * yv[2]);
    zv[2] = q16_floor(xv[0] * yv[1] - xv[1] * yv[0]);
    for (int i = 0; i < 3; i++) begin
      r.b[i]     = scale_sat(xv[i], s);
      r.b[3 + i] = scale_sat(yv[i], s);
      r.b[6 + i] = scale_sat(zv[i], s);
    end
    r.deg = d;
    return r;
  endfunction

  // Checker: every strobed word is compared with the oldest prediction.
  always @(posedge clk) begin
    basis_t exp_b;
    logic signed [31:0] got [9];
    if (!rst && done) begin
      got = '{right_x, right_y, right_z, facing_x, facing_y, facing_z,
              third_x, third_y, third_z};
      if (expected_basis.size() == 0) begin
        $display("%0t: unexpected word on done", $realtime);
        errors++;
      end else begin
        exp_b = expected_basis.pop_front();
        words_checked++;
        if (degenerate) degenerate_seen++;
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_b.b[i]) begin
            $display("%0t: basis entry %0d expected %0d actual %0d",
                     $realtime, i, exp_b.b[i], got[i]);
            errors++;
          end
        if (degenerate !== exp_b.deg) begin
          $display("%0t: degenerate expected %0b actual %0b",
                   $realtime, exp_b.deg, degenerate);
          errors++;
        end
      end
    end
  end

  // Start stays high between back-to-back words and drops only while idling or draining.
  task automatic send_word(input logic signed [31:0] p [3],
                           input logic signed [31:0] a [3],
                           input logic signed [31:0] t [3]);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
    axis_x <= a[0]; axis_y <= a[1]; axis_z <= a[2];
    target_x <= t[0]; target_y <= t[1]; target_z <= t[2];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_basis.push_back(billboard_basis(p, a, t));
    words_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_basis.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  task automatic test_directed;
    logic signed [31:0] mx, mn;
    logic signed [31:0] zero3 [3], unit_x [3], big [3], small_v [3];
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    zero3   = '{0, 0, 0};
    unit_x  = '{32'sh1_0000, 0, 0};
    big     = '{mx, mx, mx};
    small_v = '{mn, mn, mn};
    send_word(zero3, unit_x, zero3);                       // target on position
    send_word(zero3, zero3, '{0, 0, 32'sh1_0000});         // zero axis column
    send_word(zero3, unit_x, '{0, 0, 32'sh1_0000});
    send_word(zero3, unit_x, '{0, 32'sh1_0000, 0});        // straight up
    send_word(zero3, unit_x, '{0, -32'sh1_0000, 0});       // straight down
    send_word(zero3, unit_x, '{32'sh0_0800, 32'sh1_0000, 0}); // near vertical
    send_word(zero3, unit_x, '{32'sh0_0c00, 32'sh1_0000, 0});
    send_word(small_v, big, big);                          // largest distance
    send_word(big, small_v, small_v);
    send_word(big, big, big);
    send_word(small_v, small_v, '{mx, 0, mn});
    send_word('{mn, mx, 0}, big, '{mx, mn, 32'sh1234_5678});
    send_word(zero3, '{32'sh100_0000, 0, 0}, '{3, -5, 7});  // tiny distance
    send_word(zero3, '{mn, 0, 0}, '{1, 0, 0});
    send_word(zero3, unit_x, '{0, 0, 1});
    send_word('{1, 1, 1}, '{-1, -1, -1}, '{-1, -1, -1});
    send_word(zero3, '{32'sh1_0000, 32'sh2_0000, 32'sh2_0000}, '{-32'sh5_0000, 0, 0});
    drain();
  endtask

  task automatic test_random(input int count, input int pct);
    logic signed [31:0] p [3], a [3], t [3];
    int mode;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(3);
      for (int i = 0; i < 3; i++) begin
        p[i] = rand_coord(mode);
        a[i] = rand_coord($urandom_range(3));
        t[i] = rand_coord(mode);
      end
      case ($urandom_range(9))
        0: t = p;                                     // degenerate direction
        1: begin t = p; t[1] = p[1] + $signed($urandom_range(1, 32'h10_0000)); end
        2: begin t = p; t[1] = p[1] - $signed($urandom_range(1, 32'h10_0000));
                 t[0] = p[0] + $signed($urandom_range(0, 4096)) - 2048; end
        default: ;
      endcase
      send_word(p, a, t);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100, 0);
    test_random(100, 54);
    drain();                                   // sender waits for all results
    test_random(100, 0);
    test_random(100, 30);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d words, checked %0d results, %0d of them degenerate.",
             words_sent, words_checked, degenerate_seen);
    if (errors == 0 && expected_basis.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
